### sv/drld_pkg.sv
// Shared types and constants of the data run list decoder.
// No dependencies; compiled first.
package drld_pkg;

    localparam int DEF_MAX_LENGTH_BYTES = 8;
    localparam int DEF_MAX_OFFSET_BYTES = 4;
    localparam int MAX_KEPT_OFF         = 4;
    localparam int LENGTH_W             = 64;
    localparam int OFFSET_W             = 32;
    localparam int KEPT_W               = 3;

    typedef struct packed {
        logic [LENGTH_W-1:0]        run_length;
        logic signed [OFFSET_W-1:0] run_offset;
        logic                       sparse_run;
        logic                       end_of_list;
        logic                       oversize_field;
    } result_t;

endpackage

### sv/drld_if.sv
// Valid/ready channels of the data run list decoder: input bytes and decoded runs.
// Depends on drld_pkg.
interface drld_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] run_byte;

    modport source (output valid, output run_byte, input ready);
    modport sink (input valid, input run_byte, output ready);
endinterface

interface drld_run_if
    import drld_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [LENGTH_W-1:0]        run_length;
    logic signed [OFFSET_W-1:0] run_offset;
    logic                       sparse_run;
    logic                       end_of_list;
    logic                       oversize_field;

    modport source (output valid, output run_length, output run_offset,
                    output sparse_run, output end_of_list, output oversize_field,
                    input ready);
    modport sink (input valid, input run_length, input run_offset,
                  input sparse_run, input end_of_list, input oversize_field,
                  output ready);
endinterface

### sv/drld_sign_ext.sv
// Sign extension of the gathered run offset from its highest kept byte.
// Depends on drld_pkg.
module drld_sign_ext
    import drld_pkg::*;
#(
    parameter int KEPT_BYTES = DEF_MAX_OFFSET_BYTES
)(
    input  logic [8*KEPT_BYTES-1:0]  acc,
    input  logic [KEPT_W-1:0]        kept,
    output logic signed [OFFSET_W-1:0] ext
);

    logic [OFFSET_W-1:0] wide;
    logic                sign;

    assign wide = OFFSET_W'(acc);

    always_comb
    begin
        sign = 1'b0;
        unique case (kept)
            3'd1:    sign = wide[7];
            3'd2:    sign = wide[15];
            3'd3:    sign = wide[23];
            default: sign = 1'b0;
        endcase
    end

    always_comb
    begin
        ext = wide;
        for (int j = 1; j < OFFSET_W / 8; j++)
        begin
            if (sign && (kept <= KEPT_W'(j)))
            begin
                ext[8*j +: 8] = 8'hff;
            end
        end
    end

endmodule

### sv/data_run_list_decoder.sv
// Data run list decoder: one run-list byte in, one decoded run out per run.
// Depends on drld_pkg, drld_if and drld_sign_ext.
//
// The block accepts one byte per cycle with no bubbles: header, then the
// length bytes, then the offset bytes, each little-endian. Each byte updates
// a small state register as it is accepted; the decoded run (or the end of
// list marker for a zero header) is loaded into a result register at the
// clock edge that accepts its last byte and is offered in the next cycle. The
// input keeps flowing while a result waits, and stops only when the result
// register is full and not being taken. Length bytes past MAX_LENGTH_BYTES
// and offset bytes past MAX_OFFSET_BYTES (at most four) are consumed and
// dropped, and the run is flagged oversize; the offset is sign-extended from
// the highest kept byte.
module data_run_list_decoder
    import drld_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = DEF_MAX_LENGTH_BYTES,
    parameter int MAX_OFFSET_BYTES = DEF_MAX_OFFSET_BYTES
)(
    input logic        clk,
    input logic        rst_n,
    drld_byte_if.sink  bytes,
    drld_run_if.source runs
);

    localparam int KEPT_OFF = (MAX_OFFSET_BYTES < MAX_KEPT_OFF) ?
                              MAX_OFFSET_BYTES : MAX_KEPT_OFF;
    localparam int LEN_W = 8 * MAX_LENGTH_BYTES;
    localparam int OFF_W = 8 * KEPT_OFF;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_OFFSET = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic [3:0]       len_count_reg, len_count_next;
    logic [3:0]       off_count_reg, off_count_next;
    logic [3:0]       index_reg, index_next;
    logic [LEN_W-1:0] len_acc_reg, len_acc_next;
    logic [OFF_W-1:0] off_acc_reg, off_acc_next;
    logic             oversize_reg, oversize_next;
    logic             valid_reg, valid_next;
    result_t          res_reg, res_next;

    logic             accept;
    logic             load;
    logic [3:0]       index_inc;
    logic [LEN_W-1:0] len_merge;
    logic [OFF_W-1:0] off_merge;
    logic [KEPT_W-1:0] kept;
    logic signed [OFFSET_W-1:0] off_ext;

    assign accept    = bytes.valid && bytes.ready;
    assign index_inc = index_reg + 4'd1;
    assign kept      = (off_count_reg > 4'(KEPT_OFF)) ? KEPT_W'(KEPT_OFF)
                                                       : off_count_reg[KEPT_W-1:0];

    always_comb
    begin
        len_merge = len_acc_reg;
        for (int j = 0; j < MAX_LENGTH_BYTES; j++)
        begin
            if (index_reg == 4'(j))
            begin
                len_merge[8*j +: 8] = bytes.run_byte;
            end
        end
    end

    always_comb
    begin
        off_merge = off_acc_reg;
        for (int j = 0; j < KEPT_OFF; j++)
        begin
            if (index_reg == 4'(j))
            begin
                off_merge[8*j +: 8] = bytes.run_byte;
            end
        end
    end

    drld_sign_ext #(
        .KEPT_BYTES (KEPT_OFF)
    ) u_sign_ext (
        .acc  (off_merge),
        .kept (kept),
        .ext  (off_ext)
    );

    always_comb
    begin
        phase_next     = phase_reg;
        len_count_next = len_count_reg;
        off_count_next = off_count_reg;
        index_next     = index_reg;
        len_acc_next   = len_acc_reg;
        off_acc_next   = off_acc_reg;
        oversize_next  = oversize_reg;
        load           = 1'b0;
        res_next       = res_reg;

        if (accept)
        begin
            unique case (phase_reg)
                PH_LENGTH:
                begin
                    len_acc_next = len_merge;
                    index_next   = index_inc;
                    if (index_inc >= len_count_reg)
                    begin
                        index_next = 4'd0;
                        if (off_count_reg == 4'd0)
                        begin
                            phase_next              = PH_HEADER;
                            load                    = 1'b1;
                            res_next.run_length     = LENGTH_W'(len_merge);
                            res_next.run_offset     = '0;
                            res_next.sparse_run     = 1'b1;
                            res_next.end_of_list    = 1'b0;
                            res_next.oversize_field = oversize_reg;
                        end
                        else
                        begin
                            phase_next = PH_OFFSET;
                        end
                    end
                end
                PH_OFFSET:
                begin
                    off_acc_next = off_merge;
                    index_next   = index_inc;
                    if (index_inc >= off_count_reg)
                    begin
                        index_next              = 4'd0;
                        phase_next              = PH_HEADER;
                        load                    = 1'b1;
                        res_next.run_length     = LENGTH_W'(len_acc_reg);
                        res_next.run_offset     = off_ext;
                        res_next.sparse_run     = 1'b0;
                        res_next.end_of_list    = 1'b0;
                        res_next.oversize_field = oversize_reg;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                    if (bytes.run_byte == 8'h00)
                    begin
                        load                    = 1'b1;
                        res_next.run_length     = '0;
                        res_next.run_offset     = '0;
                        res_next.sparse_run     = 1'b0;
                        res_next.end_of_list    = 1'b1;
                        res_next.oversize_field = 1'b0;
                    end
                    else
                    begin
                        len_count_next = bytes.run_byte[3:0];
                        off_count_next = bytes.run_byte[7:4];
                        index_next     = 4'd0;
                        len_acc_next   = '0;
                        off_acc_next   = '0;
                        oversize_next  = (bytes.run_byte[3:0] > 4'(MAX_LENGTH_BYTES)) ||
                                         (bytes.run_byte[7:4] > 4'(MAX_OFFSET_BYTES));
                        phase_next     = (bytes.run_byte[3:0] != 4'd0) ? PH_LENGTH
                                                                       : PH_OFFSET;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (runs.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            len_count_reg <= 4'd0;
            off_count_reg <= 4'd0;
            index_reg     <= 4'd0;
            oversize_reg  <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            len_count_reg <= len_count_next;
            off_count_reg <= off_count_next;
            index_reg     <= index_next;
            oversize_reg  <= oversize_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_acc_reg <= len_acc_next;
        off_acc_reg <= off_acc_next;
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign bytes.ready         = !valid_reg || runs.ready;
    assign runs.valid          = valid_reg;
    assign runs.run_length     = res_reg.run_length;
    assign runs.run_offset     = res_reg.run_offset;
    assign runs.sparse_run     = res_reg.sparse_run;
    assign runs.end_of_list    = res_reg.end_of_list;
    assign runs.oversize_field = res_reg.oversize_field;

endmodule

### sv/drld_checker.sv
// Port-level checks of the data run list decoder, bound to the top level.
// Depends on drld_pkg and data_run_list_decoder.
module drld_checker
    import drld_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [LENGTH_W-1:0]        run_length,
    input logic signed [OFFSET_W-1:0] run_offset,
    input logic                       sparse_run,
    input logic                       end_of_list,
    input logic                       oversize_field
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(run_length) &&
        $stable(run_offset) && $stable(sparse_run) && $stable(end_of_list) &&
        $stable(oversize_field))
        else $error("result item changed while stalled");

    a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result item appeared without an accepted byte");

    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_list |-> run_length == '0 && run_offset == '0 &&
        !sparse_run && !oversize_field)
        else $error("end of list item carries run data");

    a_sparse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sparse_run |-> run_offset == '0 && !end_of_list)
        else $error("sparse run with nonzero offset");

endmodule

bind data_run_list_decoder drld_checker u_drld_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (bytes.valid),
    .in_ready       (bytes.ready),
    .out_valid      (runs.valid),
    .out_ready      (runs.ready),
    .run_length     (runs.run_length),
    .run_offset     (runs.run_offset),
    .sparse_run     (runs.sparse_run),
    .end_of_list    (runs.end_of_list),
    .oversize_field (runs.oversize_field)
);
